// File: hw/rtl/spp_pkg.sv
// ----------------------------------------------------------------------------
// spp_pkg
// Shared types, packet constants and the position encoder used by the servo
// position packet framer.
// ----------------------------------------------------------------------------
`default_nettype none

package spp_pkg;

  localparam int unsigned IdxW = 5;

  localparam logic [7:0] SYNC_BYTE      = 8'hFF;
  localparam logic [7:0] LEN_SINGLE     = 8'h09;
  localparam logic [7:0] INST_WRITE     = 8'h03;
  localparam logic [7:0] ADDR_RESET     = 8'h2A;
  localparam logic [7:0] BROADCAST_ID   = 8'hFE;
  localparam logic [7:0] LEN_SYNC       = 8'h12;
  localparam logic [7:0] INST_SYNC      = 8'h83;
  localparam logic [7:0] SERVO_DATA_LEN = 8'h06;

  localparam logic [IdxW-1:0] LAST_IDX_SINGLE = 5'd12;
  localparam logic [IdxW-1:0] LAST_IDX_SYNC   = 5'd21;

  localparam logic ACTION_SINGLE = 1'b0;
  localparam logic ACTION_SYNC   = 1'b1;

  // Register map: byte address of the start address register.
  localparam logic [2:0] ADDR_START_ADDRESS = 3'd0;

  typedef struct packed {
    logic [15:0] speed;
    logic [15:0] move_time;
    logic [15:0] position;  // sign-magnitude once encoded by the framer
    logic [7:0]  id;
  } servo_t;

  typedef struct packed {
    servo_t second;
    servo_t first;
    logic   action;
  } cmd_t;

  // Negative positions go out as sign-magnitude: bit 15 set, magnitude below.
  function automatic logic [15:0] encode_position(input logic [15:0] raw);
    logic [15:0] neg;
    neg = ~raw + 16'd1;
    if (raw[15]) begin
      return {1'b1, neg[14:0]};
    end
    return raw;
  endfunction

  // Byte k of one servo's six data bytes, low byte first.
  function automatic logic [7:0] servo_byte(input servo_t s, input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = s.position[7:0];
      3'd1:    b = s.position[15:8];
      3'd2:    b = s.move_time[7:0];
      3'd3:    b = s.move_time[15:8];
      3'd4:    b = s.speed[7:0];
      3'd5:    b = s.speed[15:8];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/spp_cfg_regs.sv
// ----------------------------------------------------------------------------
// spp_cfg_regs
// APB-style register file holding the servo memory start address.
// ----------------------------------------------------------------------------
`default_nettype none

module spp_cfg_regs
  import spp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [7:0]  start_address_o
);

  logic [7:0] start_address_q;
  logic [7:0] start_address_d;
  logic       addr_hit;

  // Registers sit on 4-byte boundaries; the low address bits are ignored.
  assign addr_hit = (paddr[2] == ADDR_START_ADDRESS[2]);
  assign pready   = 1'b1;

  always_comb begin
    start_address_d = start_address_q;
    if (psel && penable && pwrite && pready && addr_hit) begin
      start_address_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_address_q <= ADDR_RESET;
    end else begin
      start_address_q <= start_address_d;
    end
  end

  assign prdata          = addr_hit ? {24'd0, start_address_q} : 32'd0;
  assign start_address_o = start_address_q;

endmodule

`default_nettype wire

// File: hw/rtl/spp_framer.sv
// ----------------------------------------------------------------------------
// spp_framer
// Holds one command, walks through its packet bytes with a byte index and a
// running checksum, and presents each byte in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spp_framer
  import spp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  start_address_i,
  input  wire logic        cmd_valid_i,
  output logic             cmd_ready_o,
  input  wire cmd_t        cmd_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [7:0]  out_byte_o,
  output logic             out_last_o
);

  cmd_t            cmd_q, cmd_d;
  logic            cmd_valid_q, cmd_valid_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      sum_q, sum_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            out_last_q, out_last_d;

  logic            accept;
  logic            advance;
  logic            is_last;
  logic            in_sum;
  logic [7:0]      cur_byte;

  assign advance = cmd_valid_q && (!out_valid_q || out_ready_i);
  assign is_last = (cmd_q.action == ACTION_SYNC) ? (idx_q == LAST_IDX_SYNC)
                                                 : (idx_q == LAST_IDX_SINGLE);
  // A new command may enter while the last byte of the current one goes out.
  assign cmd_ready_o = !cmd_valid_q || (advance && is_last);
  assign accept      = cmd_valid_i && cmd_ready_o;
  // The two sync bytes and the checksum itself stay out of the sum.
  assign in_sum      = (idx_q >= 5'd2) && !is_last;

  always_comb begin
    cur_byte = 8'h00;
    if (is_last) begin
      cur_byte = ~sum_q;
    end else if (cmd_q.action == ACTION_SYNC) begin
      case (idx_q)
        5'd0, 5'd1: cur_byte = SYNC_BYTE;
        5'd2:       cur_byte = BROADCAST_ID;
        5'd3:       cur_byte = LEN_SYNC;
        5'd4:       cur_byte = INST_SYNC;
        5'd5:       cur_byte = start_address_i;
        5'd6:       cur_byte = SERVO_DATA_LEN;
        5'd7:       cur_byte = cmd_q.first.id;
        5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13:
          cur_byte = servo_byte(cmd_q.first, 3'(idx_q - 5'd8));
        5'd14:      cur_byte = cmd_q.second.id;
        5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20:
          cur_byte = servo_byte(cmd_q.second, 3'(idx_q - 5'd15));
        default:    cur_byte = 8'h00;
      endcase
    end else begin
      case (idx_q)
        5'd0, 5'd1: cur_byte = SYNC_BYTE;
        5'd2:       cur_byte = cmd_q.first.id;
        5'd3:       cur_byte = LEN_SINGLE;
        5'd4:       cur_byte = INST_WRITE;
        5'd5:       cur_byte = start_address_i;
        5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11:
          cur_byte = servo_byte(cmd_q.first, 3'(idx_q - 5'd6));
        default:    cur_byte = 8'h00;
      endcase
    end
  end

  always_comb begin
    cmd_d       = cmd_q;
    cmd_valid_d = cmd_valid_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (advance) begin
      out_valid_d = 1'b1;
      out_byte_d  = cur_byte;
      out_last_d  = is_last;
      if (is_last) begin
        idx_d       = '0;
        sum_d       = 8'h00;
        cmd_valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 5'd1;
        sum_d = in_sum ? (sum_q + cur_byte) : sum_q;
      end
    end

    if (accept) begin
      cmd_valid_d             = 1'b1;
      cmd_d                   = cmd_i;
      cmd_d.first.position    = encode_position(cmd_i.first.position);
      cmd_d.second.position   = encode_position(cmd_i.second.position);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      idx_q       <= '0;
      sum_q       <= 8'h00;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    out_byte_q <= out_byte_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  // The index never runs past the end of the longer packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LAST_IDX_SYNC)
    else $error("byte index out of range");

  // With no command held, the index and checksum are back at their start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_valid_q |-> (idx_q == '0) && (sum_q == 8'h00))
    else $error("framer not rewound after packet end");

  // A single write never reaches beyond its thirteenth byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_q && (cmd_q.action == ACTION_SINGLE) |-> idx_q <= LAST_IDX_SINGLE)
    else $error("single write overran its length");

  // Emitting the closing byte marks the output as last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && is_last |=> out_valid_q && out_last_q)
    else $error("checksum byte not flagged as last");

endmodule

`default_nettype wire

// File: hw/rtl/servo_position_packet_framer.sv
// ----------------------------------------------------------------------------
// servo_position_packet_framer
// Turns one servo position command into a protocol-1 instruction packet:
// a 13-byte single write or a 22-byte two-servo sync write, one byte per
// output transfer, with tlast on the checksum byte.
//
//   Channel   Direction  Content
//   s_axis    in         one position command (tuser = action)
//   m_axis    out        one packet byte (tlast = checksum byte)
//   apb       in/out     start address register at byte address 0
//
// A command goes out one packet byte per output transfer, with the byte
// index walking the held command.
// The next command is taken in the cycle its predecessor's last byte enters
// the output register, so packets follow each other without gaps.
// Reset clears the command and output valid flags and loads start address 0x2A.
// A stall on m_axis holds the current byte and pauses the byte index.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_position_packet_framer
  import spp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: first_id, first_position, first_time, first_speed,
  //        second_id, second_position, second_time, second_speed
  input  wire logic [111:0] s_axis_tdata,
  // tuser: action
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: tx_byte
  output logic      [7:0]   m_axis_tdata,
  output logic              m_axis_tlast,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);

  logic [7:0] start_address;
  cmd_t       cmd;

  assign cmd.action          = s_axis_tuser;
  assign cmd.first.id        = s_axis_tdata[7:0];
  assign cmd.first.position  = s_axis_tdata[23:8];
  assign cmd.first.move_time = s_axis_tdata[39:24];
  assign cmd.first.speed     = s_axis_tdata[55:40];
  assign cmd.second.id        = s_axis_tdata[63:56];
  assign cmd.second.position  = s_axis_tdata[79:64];
  assign cmd.second.move_time = s_axis_tdata[95:80];
  assign cmd.second.speed     = s_axis_tdata[111:96];

  spp_cfg_regs u_cfg_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .start_address_o (start_address)
  );

  spp_framer u_framer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_address_i (start_address),
    .cmd_valid_i     (s_axis_tvalid),
    .cmd_ready_o     (s_axis_tready),
    .cmd_i           (cmd),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_byte_o      (m_axis_tdata),
    .out_last_o      (m_axis_tlast)
  );

endmodule

`default_nettype wire
